@@ rtl/qrrs_pkg.sv @@
// Shared constants, types and GF(256) arithmetic for the QR Reed-Solomon parity encoder.
// No dependencies; every other file of the block refers to this package by scoped names.
package qrrs_pkg;

    // Largest number of parity bytes per block.
    localparam int MAX_PARITY = 32;
    // Width of a length or count that can hold the value MAX_PARITY itself.
    localparam int LEN_W = $clog2(MAX_PARITY + 1);
    // Width of the parity_length register.
    localparam int CFG_W = 6;
    // Reset value of the parity_length register.
    localparam logic [CFG_W-1:0] PARITY_LEN_RESET = 6'd10;
    // Low byte of the field polynomial x^8+x^4+x^3+x^2+1.
    localparam logic [7:0] FIELD_POLY_LO = 8'h1d;
    // Register index of parity_length in the configuration map.
    localparam logic REG_PARITY_LEN = 1'b0;

    typedef logic [7:0] byte_arr_t [MAX_PARITY];

    // Control that goes with a block of parity bytes handed to the output buffer.
    typedef struct packed {
        logic             load;
        logic [LEN_W-1:0] len;
    } par_load_t;

    // General GF(256) product, one shift-and-add step for each bit of y.
    function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] a;
        logic [7:0] p;
        a = x;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (y[i])
            begin
                p = p ^ a;
            end
            a = {a[6:0], 1'b0} ^ (a[7] ? FIELD_POLY_LO : 8'h00);
        end
        return p;
    endfunction

    // Multiplication by alpha (the value 2).
    function automatic logic [7:0] gf_xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? FIELD_POLY_LO : 8'h00);
    endfunction

    // Effective number of parity bytes: zero is taken as one, excess as MAX_PARITY.
    function automatic logic [LEN_W-1:0] clamp_len(input logic [CFG_W-1:0] v);
        logic [CFG_W:0] wide;
        logic [CFG_W:0] lim;
        wide = {1'b0, v};
        lim  = (CFG_W + 1)'(MAX_PARITY);
        if (wide == '0)
        begin
            return LEN_W'(1);
        end
        else if (wide > lim)
        begin
            return LEN_W'(MAX_PARITY);
        end
        return LEN_W'(wide);
    endfunction

endpackage

@@ rtl/qrrs_gen.sv @@
// Generator polynomial builder: multiplies (x - alpha^i) into the product, one root per cycle.
// Depends on qrrs_pkg.
module qrrs_gen
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [qrrs_pkg::LEN_W-1:0]   len,
    output logic                         busy,
    output qrrs_pkg::byte_arr_t          coeffs
);

    localparam logic [qrrs_pkg::LEN_W-1:0] LEN_ONE = qrrs_pkg::LEN_W'(1);

    logic                       busy_reg;
    logic [qrrs_pkg::LEN_W-1:0] count_reg;
    logic [7:0]                 root_reg;
    qrrs_pkg::byte_arr_t        coeff_reg;
    qrrs_pkg::byte_arr_t        coeff_next;

    // One step of the product: g[j] ^= g[j-1] * root for every j, with the leading 1 implicit.
    always_comb
    begin
        for (int k = 0; k < qrrs_pkg::MAX_PARITY; k++)
        begin
            if (k == 0)
            begin
                coeff_next[k] = coeff_reg[k] ^ root_reg;
            end
            else
            begin
                coeff_next[k] = coeff_reg[k] ^ qrrs_pkg::gf_mul(coeff_reg[k-1], root_reg);
            end
        end
    end

    // Build sequencer: a reset or a length write restarts the product from 1.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b1;
            count_reg <= '0;
            root_reg  <= 8'h01;
            for (int k = 0; k < qrrs_pkg::MAX_PARITY; k++)
            begin
                coeff_reg[k] <= 8'h00;
            end
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            count_reg <= '0;
            root_reg  <= 8'h01;
            for (int k = 0; k < qrrs_pkg::MAX_PARITY; k++)
            begin
                coeff_reg[k] <= 8'h00;
            end
        end
        else if (busy_reg)
        begin
            if (count_reg == len)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                coeff_reg <= coeff_next;
                root_reg  <= qrrs_pkg::gf_xtime(root_reg);
                count_reg <= count_reg + LEN_ONE;
            end
        end
    end

    assign busy   = busy_reg;
    assign coeffs = coeff_reg;

endmodule

@@ rtl/qrrs_lfsr.sv @@
// Input register and parity remainder register with its parallel GF feedback update.
// Depends on qrrs_pkg.
module qrrs_lfsr
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,    // [7:0] data_byte
    input  logic                        s_tlast,
    input  logic                        gen_busy,
    input  qrrs_pkg::byte_arr_t         coeffs,
    input  logic                        clear,
    input  logic                        out_idle,
    input  logic [qrrs_pkg::LEN_W-1:0]  len,
    output qrrs_pkg::par_load_t         par_load,
    output qrrs_pkg::byte_arr_t         par_data
);

    logic                in_valid_reg;
    logic [7:0]          in_data_reg;
    logic                in_last_reg;
    qrrs_pkg::byte_arr_t rem_reg;
    qrrs_pkg::byte_arr_t rem_next;
    logic [7:0]          fb;
    logic                consume;

    // A last item waits here until the output buffer has emptied.
    assign consume  = in_valid_reg && !gen_busy && (!in_last_reg || out_idle);
    assign s_tready = !gen_busy && (!in_valid_reg || !in_last_reg || out_idle);

    // Remainder update: shift down by one byte and add the feedback times the generator.
    assign fb = in_data_reg ^ rem_reg[0];
    always_comb
    begin
        for (int i = 0; i < qrrs_pkg::MAX_PARITY; i++)
        begin
            if (i == qrrs_pkg::MAX_PARITY - 1)
            begin
                rem_next[i] = qrrs_pkg::gf_mul(coeffs[i], fb);
            end
            else
            begin
                rem_next[i] = rem_reg[i+1] ^ qrrs_pkg::gf_mul(coeffs[i], fb);
            end
        end
    end

    assign par_load.load = consume && in_last_reg;
    assign par_load.len  = len;
    assign par_data      = rem_next;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (consume)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Remainder register: cleared at the end of each block and on a length write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < qrrs_pkg::MAX_PARITY; i++)
            begin
                rem_reg[i] <= 8'h00;
            end
        end
        else if (clear || (consume && in_last_reg))
        begin
            for (int i = 0; i < qrrs_pkg::MAX_PARITY; i++)
            begin
                rem_reg[i] <= 8'h00;
            end
        end
        else if (consume)
        begin
            rem_reg <= rem_next;
        end
    end

endmodule

@@ rtl/qrrs_par_out.sv @@
// Parity output buffer: holds one block of parity bytes and shifts them out one per item.
// Depends on qrrs_pkg.
module qrrs_par_out
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  qrrs_pkg::par_load_t         par_load,
    input  qrrs_pkg::byte_arr_t         par_data,
    output logic                        out_idle,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,    // [7:0] parity_byte
    output logic                        m_tlast
);

    localparam logic [qrrs_pkg::LEN_W-1:0] LEN_ONE = qrrs_pkg::LEN_W'(1);

    logic [qrrs_pkg::LEN_W-1:0] cnt_reg;
    qrrs_pkg::byte_arr_t        buf_reg;

    // Count of parity bytes still to be delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (par_load.load)
        begin
            cnt_reg <= par_load.len;
        end
        else if (m_tvalid && m_tready)
        begin
            cnt_reg <= cnt_reg - LEN_ONE;
        end
    end

    // Byte buffer, highest-order coefficient at the head.
    always_ff @(posedge clk)
    begin
        if (par_load.load)
        begin
            buf_reg <= par_data;
        end
        else if (m_tvalid && m_tready)
        begin
            for (int i = 0; i < qrrs_pkg::MAX_PARITY - 1; i++)
            begin
                buf_reg[i] <= buf_reg[i+1];
            end
        end
    end

    assign out_idle = (cnt_reg == '0);
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = buf_reg[0];
    assign m_tlast  = (cnt_reg == LEN_ONE);

endmodule

@@ rtl/qr_reed_solomon_parity_encoder.sv @@
// Encoder top level; depends on qrrs_pkg, qrrs_gen, qrrs_lfsr and qrrs_par_out.
// A block's first parity item is offered once its last data item has loaded the output buffer.
// Throughput: one data item per cycle while gen_busy is low; L parity items one per cycle while
// m_tready is high; the next block's last item waits in the input register until they drain.
// Reset and every parity_length write hold tready low for L + 1 cycles while the generator
// is rebuilt (L = 10 after reset); a write also drops any block in progress.
module qr_reed_solomon_parity_encoder
(
    input  logic        clk,
    input  logic        rst_n,
    // Data items in.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tlast,    // last_data
    // Parity items out.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] parity_byte
    output logic        m_tlast,    // last_parity
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [qrrs_pkg::CFG_W-1:0] plen_reg;
    logic [qrrs_pkg::LEN_W-1:0] eff_len;
    logic                       cfg_wr;
    logic                       gen_busy;
    logic                       out_idle;
    qrrs_pkg::byte_arr_t        coeffs;
    qrrs_pkg::byte_arr_t        par_data;
    qrrs_pkg::par_load_t        par_load;

    // Register access: parity_length is the only register.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == qrrs_pkg::REG_PARITY_LEN);
    assign prdata = (paddr[2] == qrrs_pkg::REG_PARITY_LEN) ? 32'(plen_reg) : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg <= qrrs_pkg::PARITY_LEN_RESET;
        end
        else if (cfg_wr)
        begin
            plen_reg <= pwdata[qrrs_pkg::CFG_W-1:0];
        end
    end

    assign eff_len = qrrs_pkg::clamp_len(plen_reg);

    // Generator builder.
    qrrs_gen u_gen
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cfg_wr),
        .len    (eff_len),
        .busy   (gen_busy),
        .coeffs (coeffs)
    );

    // Input register and remainder update.
    qrrs_lfsr u_lfsr
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .gen_busy (gen_busy),
        .coeffs   (coeffs),
        .clear    (cfg_wr),
        .out_idle (out_idle),
        .len      (eff_len),
        .par_load (par_load),
        .par_data (par_data)
    );

    // Parity output buffer.
    qrrs_par_out u_par_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .par_load (par_load),
        .par_data (par_data),
        .out_idle (out_idle),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
